// File: rtl/lppu_pkg.sv
// ============================================================================
// Lidar projection package
// Widths, configuration types and register codes shared by the projection
// unit's modules.
// ============================================================================
package lppu_pkg;

    // Field sizes.
    localparam int COORD_BITS     = 20;
    localparam int COEF_FRAC_BITS = 14;
    localparam int ROT_W          = 16;
    localparam int TRANS_W        = 16;
    localparam int INTR_W         = 20;
    localparam int ROT_REG_W      = 3 * ROT_W;
    localparam int INTR_REG_W     = 3 * INTR_W;
    localparam int CFG_DATA_W     = INTR_REG_W;
    localparam int CFG_IDX_W      = 3;

    // Camera-frame arithmetic.
    localparam int WIDEST  = (COORD_BITS > COEF_FRAC_BITS) ? COORD_BITS : COEF_FRAC_BITS;
    localparam int DROP    = (WIDEST > 22) ? (WIDEST - 22) : 0;
    localparam int PROD_W  = ROT_W + COORD_BITS;
    localparam int TSH_W   = TRANS_W + COEF_FRAC_BITS;
    localparam int SUM_W   = ((PROD_W > TSH_W) ? PROD_W : TSH_W) + 2;
    localparam int CAM_W   = SUM_W - DROP;

    // Projection arithmetic: camera coordinates are split in two halves.
    localparam int LO_W    = CAM_W / 2;
    localparam int HI_W    = CAM_W - LO_W;
    localparam int PLO_W   = INTR_W + LO_W + 1;
    localparam int PHI_W   = INTR_W + HI_W;
    localparam int NUM_W   = INTR_W + CAM_W + 2;

    // Divider.
    localparam int QB      = COORD_BITS;
    localparam int NW      = NUM_W + 2;
    localparam int DW      = CAM_W;
    localparam int CMP_W   = (NW > DW + QB) ? NW : (DW + QB);

    // Queues.
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = 2;
    localparam int OQ_DEPTH = 32;
    localparam int OQ_AW    = 5;

    // Pixel limits.
    localparam logic signed [COORD_BITS-1:0] PIX_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] PIX_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_ROT_X  = 3'd0,
        IDX_ROT_Y  = 3'd1,
        IDX_ROT_Z  = 3'd2,
        IDX_TRANS  = 3'd3,
        IDX_INTR_U = 3'd4,
        IDX_INTR_V = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [ROT_REG_W-1:0]  rot_x;
        logic [ROT_REG_W-1:0]  rot_y;
        logic [ROT_REG_W-1:0]  rot_z;
        logic [ROT_REG_W-1:0]  trans;
        logic [INTR_REG_W-1:0] intr_u;
        logic [INTR_REG_W-1:0] intr_v;
    } cfg_t;

    // One point in the camera frame.
    typedef struct packed {
        logic signed [CAM_W-1:0] x;
        logic signed [CAM_W-1:0] y;
        logic signed [CAM_W-1:0] z;
        logic                    inv;
    } cam_t;

    // Handshake between front and back.
    typedef struct packed {
        logic empty;
        cam_t head;
    } mq_side_t;

endpackage

// File: rtl/lppu_cfg.sv
// ============================================================================
// Lidar projection configuration registers
// Holds the rotation, translation and intrinsic registers.
// ============================================================================
module lppu_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lppu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lppu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lppu_pkg::cfg_t                   cfg
);
    import lppu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_ROT_X:  cfg_next.rot_x  = cfg_data[ROT_REG_W-1:0];
                IDX_ROT_Y:  cfg_next.rot_y  = cfg_data[ROT_REG_W-1:0];
                IDX_ROT_Z:  cfg_next.rot_z  = cfg_data[ROT_REG_W-1:0];
                IDX_TRANS:  cfg_next.trans  = cfg_data[ROT_REG_W-1:0];
                IDX_INTR_U: cfg_next.intr_u = cfg_data[INTR_REG_W-1:0];
                IDX_INTR_V: cfg_next.intr_v = cfg_data[INTR_REG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lppu_front.sv
// ============================================================================
// Lidar projection front end
// Accepts points, applies the rigid transform, flags invalid depth and
// queues camera-frame points for the back end.
// ============================================================================
module lppu_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lppu_pkg::cfg_t                        cfg,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_x_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_y_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_z_mm,
    output lppu_pkg::mq_side_t                    mq,
    input  logic                                  mq_pop
);
    import lppu_pkg::*;

    logic                       push_acc;
    logic [ROT_REG_W-1:0]       rot [3];
    logic signed [COORD_BITS-1:0] pt [3];
    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic signed [TSH_W-1:0]    tsh_reg [3];
    logic                       f1_v_reg;
    logic signed [SUM_W-1:0]    sum [3];
    cam_t                       cam;
    cam_t                       mq_mem [MQ_DEPTH];
    logic [MQ_AW-1:0]           wptr_reg;
    logic [MQ_AW-1:0]           rptr_reg;
    logic [MQ_AW:0]             mq_cnt_reg;
    logic [MQ_AW:0]             mq_cnt_next;
    logic [MQ_AW:0]             cr_cnt_reg;
    logic [MQ_AW:0]             cr_cnt_next;

    assign rot[0] = cfg.rot_x;
    assign rot[1] = cfg.rot_y;
    assign rot[2] = cfg.rot_z;
    assign pt[0]  = point_x_mm;
    assign pt[1]  = point_y_mm;
    assign pt[2]  = point_z_mm;

    // Points in flight plus queued points never exceed the queue depth.
    assign full     = (cr_cnt_reg == (MQ_AW+1)'(MQ_DEPTH));
    assign push_acc = push && !full;

    // Stage one: rotation products and scaled translation.
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r][k] <= PROD_W'($signed(rot[r][k*ROT_W +: ROT_W]))
                                    * PROD_W'(pt[k]);
                end
                tsh_reg[r] <= TSH_W'($signed(cfg.trans[r*TRANS_W +: TRANS_W]))
                              <<< COEF_FRAC_BITS;
            end
        end
    end

    // Stage two: sums, floor of the dropped bits and depth check.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                   + SUM_W'(prod_reg[r][2]) + SUM_W'(tsh_reg[r]);
        end
        cam.x   = sum[0][SUM_W-1:DROP];
        cam.y   = sum[1][SUM_W-1:DROP];
        cam.z   = sum[2][SUM_W-1:DROP];
        cam.inv = cam.z[CAM_W-1] || (cam.z == '0);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (f1_v_reg)
        begin
            mq_mem[wptr_reg] <= cam;
        end
    end

    always_comb
    begin
        mq_cnt_next = mq_cnt_reg;
        cr_cnt_next = cr_cnt_reg;
        if (f1_v_reg)
        begin
            mq_cnt_next = mq_cnt_next + 1'b1;
        end
        if (mq_pop)
        begin
            mq_cnt_next = mq_cnt_next - 1'b1;
            cr_cnt_next = cr_cnt_next - 1'b1;
        end
        if (push_acc)
        begin
            cr_cnt_next = cr_cnt_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg   <= 1'b0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            mq_cnt_reg <= '0;
            cr_cnt_reg <= '0;
        end
        else
        begin
            f1_v_reg   <= push_acc;
            mq_cnt_reg <= mq_cnt_next;
            cr_cnt_reg <= cr_cnt_next;
            if (f1_v_reg)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (mq_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    assign mq.empty = (mq_cnt_reg == '0);
    assign mq.head  = mq_mem[rptr_reg];

endmodule

// File: rtl/lppu_back.sv
// ============================================================================
// Lidar projection back end
// Applies the intrinsics, divides by depth one quotient bit per stage,
// rounds, clips and queues the results.
// ============================================================================
module lppu_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lppu_pkg::cfg_t                         cfg,
    input  lppu_pkg::mq_side_t                     mq,
    output logic                                   mq_pop,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [lppu_pkg::COORD_BITS-1:0] pixel_u,
    output logic signed [lppu_pkg::COORD_BITS-1:0] pixel_v,
    output logic                                   depth_invalid,
    output logic                                   saturated
);
    import lppu_pkg::*;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QB-1:0] q;
        logic          ovf;
        logic          neg;
    } lane_t;

    typedef struct packed {
        lane_t         u;
        lane_t         v;
        logic [DW-1:0] d;
        logic          inv;
    } dstage_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] u;
        logic signed [COORD_BITS-1:0] v;
        logic                         inv;
        logic                         sat;
    } res_t;

    // One restoring division step at quotient bit i.
    function automatic lane_t div_step(input lane_t a, input logic [DW-1:0] d,
                                       input int i);
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] r;
        lane_t            o;
        t = CMP_W'(d) << i;
        r = CMP_W'(a.rem);
        o = a;
        if (r >= t)
        begin
            o.rem = NW'(r - t);
            o.q   = a.q | (QB'(1) << i);
        end
        return o;
    endfunction

    // Numerator magnitude set-up and overflow check.
    function automatic lane_t lane_init(input logic signed [NUM_W-1:0] num,
                                        input logic [DW-1:0] d,
                                        input logic signed [CAM_W-1:0] den);
        logic [NUM_W-1:0] mag;
        lane_t            o;
        o.neg = num[NUM_W-1];
        mag   = o.neg ? (~num + 1'b1) : num;
        o.rem = NW'({mag, 1'b0}) + NW'(den[CAM_W-2:0]);
        o.ovf = CMP_W'(o.rem) >= (CMP_W'(d) << QB);
        o.q   = '0;
        return o;
    endfunction

    // Rounded quotient to a clipped pixel coordinate.
    function automatic logic [COORD_BITS:0] lane_fin(input lane_t a);
        logic [QB:0] q;
        logic [QB:0] lim;
        logic        sat;
        q   = {1'b0, a.q};
        lim = a.neg ? ((QB+1)'(1) << (QB-1)) : (((QB+1)'(1) << (QB-1)) - 1'b1);
        sat = 1'b0;
        if (a.ovf || (q > lim))
        begin
            q   = lim;
            sat = 1'b1;
        end
        if (a.neg)
        begin
            q = ~q + 1'b1;
        end
        return {sat, q[QB-1:0]};
    endfunction

    logic [INTR_REG_W-1:0]        intr [2];
    logic signed [CAM_W-1:0]      c [3];
    logic signed [PLO_W-1:0]      plo_reg [2][3];
    logic signed [PHI_W-1:0]      phi_reg [2][3];
    logic signed [CAM_W-1:0]      den1_reg;
    logic                         inv1_reg;
    logic                         b1_v_reg;
    logic signed [NUM_W-1:0]      num_reg [2];
    logic signed [CAM_W-1:0]      den2_reg;
    logic                         inv2_reg;
    logic                         b2_v_reg;
    logic [DW-1:0]                d2;
    dstage_t                      stg_reg [QB+1];
    logic [QB:0]                  vld_reg;
    logic [COORD_BITS:0]          fin_u;
    logic [COORD_BITS:0]          fin_v;
    res_t                         res;
    res_t                         oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]             wptr_reg;
    logic [OQ_AW-1:0]             rptr_reg;
    logic [OQ_AW:0]               oq_cnt_reg;
    logic [OQ_AW:0]               oq_cnt_next;
    logic [OQ_AW:0]               cr_cnt_reg;
    logic [OQ_AW:0]               cr_cnt_next;
    logic                         pop_acc;
    logic                         oq_wr;

    assign intr[0] = cfg.intr_u;
    assign intr[1] = cfg.intr_v;
    assign c[0]    = mq.head.x;
    assign c[1]    = mq.head.y;
    assign c[2]    = mq.head.z;

    // Issue only with room reserved in the result queue.
    assign pop_acc = pop && !empty;
    assign mq_pop  = !mq.empty && (cr_cnt_reg != (OQ_AW+1)'(OQ_DEPTH));

    // Stage one: intrinsic products on both halves of each coordinate.
    always_ff @(posedge clk)
    begin
        if (mq_pop)
        begin
            for (int r = 0; r < 2; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    plo_reg[r][k] <= PLO_W'($signed(intr[r][k*INTR_W +: INTR_W]))
                                   * PLO_W'($signed({1'b0, c[k][LO_W-1:0]}));
                    phi_reg[r][k] <= PHI_W'($signed(intr[r][k*INTR_W +: INTR_W]))
                                   * PHI_W'($signed(c[k][CAM_W-1:LO_W]));
                end
            end
            den1_reg <= c[2];
            inv1_reg <= mq.head.inv;
        end
    end

    // Stage two: numerators.
    always_ff @(posedge clk)
    begin
        if (b1_v_reg)
        begin
            for (int r = 0; r < 2; r++)
            begin
                num_reg[r] <= ((NUM_W'(phi_reg[r][0]) + NUM_W'(phi_reg[r][1])
                              + NUM_W'(phi_reg[r][2])) <<< LO_W)
                            + NUM_W'(plo_reg[r][0]) + NUM_W'(plo_reg[r][1])
                            + NUM_W'(plo_reg[r][2]);
            end
            den2_reg <= den1_reg;
            inv2_reg <= inv1_reg;
        end
    end

    // Stage three: divider operands and overflow check.
    assign d2 = {den2_reg[CAM_W-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (b2_v_reg)
        begin
            stg_reg[0].u   <= lane_init(num_reg[0], d2, den2_reg);
            stg_reg[0].v   <= lane_init(num_reg[1], d2, den2_reg);
            stg_reg[0].d   <= d2;
            stg_reg[0].inv <= inv2_reg;
        end
    end

    // Divider stages, most significant quotient bit first.
    for (genvar s = 1; s <= QB; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (vld_reg[s-1])
            begin
                stg_reg[s].u   <= div_step(stg_reg[s-1].u, stg_reg[s-1].d, QB - s);
                stg_reg[s].v   <= div_step(stg_reg[s-1].v, stg_reg[s-1].d, QB - s);
                stg_reg[s].d   <= stg_reg[s-1].d;
                stg_reg[s].inv <= stg_reg[s-1].inv;
            end
        end
    end

    // Final clipping; an invalid depth gives zero pixels.
    always_comb
    begin
        fin_u   = lane_fin(stg_reg[QB].u);
        fin_v   = lane_fin(stg_reg[QB].v);
        res.inv = stg_reg[QB].inv;
        res.u   = res.inv ? '0 : $signed(fin_u[COORD_BITS-1:0]);
        res.v   = res.inv ? '0 : $signed(fin_v[COORD_BITS-1:0]);
        res.sat = !res.inv && (fin_u[COORD_BITS] || fin_v[COORD_BITS]);
    end

    assign oq_wr = vld_reg[QB];

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_mem[wptr_reg] <= res;
        end
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        cr_cnt_next = cr_cnt_reg;
        if (oq_wr)
        begin
            oq_cnt_next = oq_cnt_next + 1'b1;
        end
        if (pop_acc)
        begin
            oq_cnt_next = oq_cnt_next - 1'b1;
            cr_cnt_next = cr_cnt_next - 1'b1;
        end
        if (mq_pop)
        begin
            cr_cnt_next = cr_cnt_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg   <= 1'b0;
            b2_v_reg   <= 1'b0;
            vld_reg    <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            oq_cnt_reg <= '0;
            cr_cnt_reg <= '0;
        end
        else
        begin
            b1_v_reg   <= mq_pop;
            b2_v_reg   <= b1_v_reg;
            vld_reg    <= {vld_reg[QB-1:0], b2_v_reg};
            oq_cnt_reg <= oq_cnt_next;
            cr_cnt_reg <= cr_cnt_next;
            if (oq_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop_acc)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    assign empty         = (oq_cnt_reg == '0);
    assign pixel_u       = oq_mem[rptr_reg].u;
    assign pixel_v       = oq_mem[rptr_reg].v;
    assign depth_invalid = oq_mem[rptr_reg].inv;
    assign saturated     = oq_mem[rptr_reg].sat;

endmodule

// File: rtl/lidar_point_to_pixel_projection_unit.sv
// ============================================================================
// Lidar point to pixel projection unit
// Rigid transform of a lidar point into the camera frame, pinhole projection
// and division by depth, with saturation and depth flags.
// ============================================================================
// The unit takes one point per clock while full is low and returns one
// result per point, in order. A point passes the transform front end's
// product register and sum logic, then a four-entry queue, into the
// projection back end: two multiply and sum stages, an operand stage and a
// twenty-stage divider that resolves one quotient bit per stage. Results
// wait in a 32-entry queue; the back end issues a point only when a slot
// there is reserved, so throughput stays at one per clock as long as pop
// keeps up. Configuration writes take effect on the next clock and should
// be made while no point is in flight.
module lidar_point_to_pixel_projection_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_x_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_y_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_z_mm,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [lppu_pkg::COORD_BITS-1:0] pixel_u,
    output logic signed [lppu_pkg::COORD_BITS-1:0] pixel_v,
    output logic                                   depth_invalid,
    output logic                                   saturated,
    input  logic                                   cfg_we,
    input  logic [lppu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lppu_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import lppu_pkg::*;

    cfg_t     cfg;
    mq_side_t mq;
    logic     mq_pop;

    // Configuration registers.
    lppu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Transform front end.
    lppu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .push       (push),
        .full       (full),
        .point_x_mm (point_x_mm),
        .point_y_mm (point_y_mm),
        .point_z_mm (point_z_mm),
        .mq         (mq),
        .mq_pop     (mq_pop)
    );

    // Projection back end.
    lppu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .mq            (mq),
        .mq_pop        (mq_pop),
        .empty         (empty),
        .pop           (pop),
        .pixel_u       (pixel_u),
        .pixel_v       (pixel_v),
        .depth_invalid (depth_invalid),
        .saturated     (saturated)
    );

endmodule

// File: rtl/lppu_checker.sv
// ============================================================================
// Lidar projection port checker
// Checks result consistency and queue behavior seen at the top-level ports.
// ============================================================================
module lppu_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic                                   empty,
    input  logic                                   pop,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] pixel_u,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] pixel_v,
    input  logic                                   depth_invalid,
    input  logic                                   saturated
);
    import lppu_pkg::*;

    // The result queue is empty while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // An invalid depth gives zero pixels and no saturation.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && depth_invalid) |-> (pixel_u == '0 && pixel_v == '0 && !saturated))
        else $error("invalid depth beat carries data");

    // A saturated beat has a coordinate at a limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && saturated) |-> (pixel_u == PIX_MAX || pixel_u == PIX_MIN
                                || pixel_v == PIX_MAX || pixel_v == PIX_MIN))
        else $error("saturated beat not at a limit");

    // A waiting result beat holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_u) && $stable(pixel_v)))
        else $error("waiting result beat changed");

endmodule

bind lidar_point_to_pixel_projection_unit lppu_checker u_lppu_checker (.*);

// File: test/lidar_point_to_pixel_projection_unit_checker.sv
// ============================================================================
// Lidar projection result checker
// Mirrors the configuration writes, predicts the pixel beat for every point
// beat taken by the unit and compares each result beat with the oldest
// prediction, field by field.
// ============================================================================
module lidar_point_to_pixel_projection_unit_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_x_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_y_mm,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] point_z_mm,
    input  logic                                   empty,
    input  logic                                   pop,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] pixel_u,
    input  logic signed [lppu_pkg::COORD_BITS-1:0] pixel_v,
    input  logic                                   depth_invalid,
    input  logic                                   saturated,
    input  logic                                   cfg_we,
    input  logic [lppu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lppu_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                     fail_count,
    output int                                     pixels_pending
);
    import lppu_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] u;
        logic signed [COORD_BITS-1:0] v;
        logic                         inv;
        logic                         sat;
    } pixel_t;

    pixel_t pixel_queue[$];

    // Shadow copy of the unit's registers.
    logic [ROT_REG_W-1:0]  rot_x, rot_y, rot_z, trans;
    logic [INTR_REG_W-1:0] intr_u, intr_v;

    function automatic longint field16(logic [ROT_REG_W-1:0] r, int idx);
        logic [15:0] f;
        f = 16'(r >> (16 * idx));
        return longint'($signed(f));
    endfunction

    function automatic longint field20(logic [INTR_REG_W-1:0] r, int idx);
        logic [19:0] f;
        f = 20'(r >> (20 * idx));
        return longint'($signed(f));
    endfunction

    // Rotation row times point plus the translation, kept in Q.14 millimetres.
    function automatic longint camera_coord(logic [ROT_REG_W-1:0] row, longint t,
                                            longint px, longint py, longint pz);
        longint s;
        s = field16(row, 0) * px + field16(row, 1) * py + field16(row, 2) * pz;
        s = s + t * (longint'(1) << COEF_FRAC_BITS);
        return s >>> DROP;
    endfunction

    // Intrinsic row over depth, rounded half away from zero, then clipped.
    function automatic logic [COORD_BITS-1:0] pixel_coord(logic [INTR_REG_W-1:0] row,
            longint cx, longint cy, longint cz, inout logic sat);
        longint num;
        longint unsigned mag, q, den, lim_pos, lim_neg;
        logic neg;
        num = field20(row, 0) * cx + field20(row, 1) * cy + field20(row, 2) * cz;
        den = cz;
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        q = (mag * 2 + den) / (den * 2);
        lim_pos = (64'd1 << (COORD_BITS - 1)) - 1;
        lim_neg = 64'd1 << (COORD_BITS - 1);
        if (neg) begin
            if (q > lim_neg) begin
                q = lim_neg;
                sat = 1'b1;
            end
            q = -q;
        end
        else if (q > lim_pos) begin
            q = lim_pos;
            sat = 1'b1;
        end
        return q[COORD_BITS-1:0];
    endfunction

    function automatic pixel_t project_point(longint px, longint py, longint pz);
        pixel_t r;
        longint cx, cy, cz;
        cx = camera_coord(rot_x, field16(trans, 0), px, py, pz);
        cy = camera_coord(rot_y, field16(trans, 1), px, py, pz);
        cz = camera_coord(rot_z, field16(trans, 2), px, py, pz);
        r.u = '0;
        r.v = '0;
        r.sat = 1'b0;
        r.inv = cz <= 0;
        if (!r.inv) begin
            r.u = pixel_coord(intr_u, cx, cy, cz, r.sat);
            r.v = pixel_coord(intr_v, cx, cy, cz, r.sat);
        end
        return r;
    endfunction

    // All ports are stable at the falling edge; what is seen here is what the
    // next rising edge takes.
    always @(negedge clk or negedge rst_n) begin
        pixel_t want;
        if (!rst_n) begin
            rot_x = '0; rot_y = '0; rot_z = '0; trans = '0;
            intr_u = '0; intr_v = '0;
            fail_count = 0;
            pixel_queue.delete();
        end
        else begin
            if (push && !full)
                pixel_queue.insert(pixel_queue.size(),
                                   project_point(point_x_mm, point_y_mm, point_z_mm));
            if (pop && !empty) begin
                if (pixel_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with no point waiting: u=%0d v=%0d",
                             $time, pixel_u, pixel_v);
                end
                else begin
                    want = pixel_queue.pop_front();
                    if (pixel_u !== want.u) begin
                        fail_count++;
                        $display("%0t: pixel_u expected %0d actual %0d", $time, want.u, pixel_u);
                    end
                    if (pixel_v !== want.v) begin
                        fail_count++;
                        $display("%0t: pixel_v expected %0d actual %0d", $time, want.v, pixel_v);
                    end
                    if (depth_invalid !== want.inv) begin
                        fail_count++;
                        $display("%0t: depth_invalid expected %0b actual %0b",
                                 $time, want.inv, depth_invalid);
                    end
                    if (saturated !== want.sat) begin
                        fail_count++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.sat, saturated);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    IDX_ROT_X:  rot_x  = cfg_data[ROT_REG_W-1:0];
                    IDX_ROT_Y:  rot_y  = cfg_data[ROT_REG_W-1:0];
                    IDX_ROT_Z:  rot_z  = cfg_data[ROT_REG_W-1:0];
                    IDX_TRANS:  trans  = cfg_data[ROT_REG_W-1:0];
                    IDX_INTR_U: intr_u = cfg_data[INTR_REG_W-1:0];
                    IDX_INTR_V: intr_v = cfg_data[INTR_REG_W-1:0];
                    default: ;
                endcase
            end
        end
        pixels_pending = pixel_queue.size();
    end

endmodule

// File: test/lidar_point_to_pixel_projection_unit_tb.sv
// ============================================================================
// Lidar projection unit testbench
// Drives point beats through six register settings (identity, random poses,
// all-ones, most-negative and fully random fields) with random idling on
// both sides and one long receiver hold; the checker predicts and compares.
// ============================================================================
module lidar_point_to_pixel_projection_unit_tb;
    import lppu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;

    logic clk, rst_n, push, full, empty, pop;
    logic signed [COORD_BITS-1:0] point_x_mm, point_y_mm, point_z_mm;
    logic signed [COORD_BITS-1:0] pixel_u, pixel_v;
    logic depth_invalid, saturated, cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count, pixels_pending;
    int stall_cycles = 0;
    bit hold_req, no_idle;

    lidar_point_to_pixel_projection_unit u_top (.*);

    lidar_point_to_pixel_projection_unit_checker u_checker (.*);

    // Clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random pop bursts and one long hold to fill the unit.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles in which no beat moves.
    always @(negedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [CFG_DATA_W-1:0] pack16(int a, int b, int c);
        return CFG_DATA_W'({16'(c), 16'(b), 16'(a)});
    endfunction

    function automatic logic [INTR_REG_W-1:0] pack20(int a, int b, int c);
        return {20'(c), 20'(b), 20'(a)};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // One point beat; push stays high until the unit takes it.
    task automatic send_point(int x, int y, int z);
        bit taken;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push       <= 1'b1;
        point_x_mm <= COORD_BITS'(x);
        point_y_mm <= COORD_BITS'(y);
        point_z_mm <= COORD_BITS'(z);
        do begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic send_random_point();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            send_point($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                       $urandom_range(1, 200000));
        else
            send_point($urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Register setting for each phase of the run.
    task automatic configure(int phase);
        logic [CFG_DATA_W-1:0] r[6];
        case (phase)
            0: begin
                r[0] = pack16(16384, 0, 0);
                r[1] = pack16(0, 16384, 0);
                r[2] = pack16(0, 0, 16384);
                r[3] = pack16(0, 0, 0);
                r[4] = pack20(8000, 0, 5120);
                r[5] = pack20(0, 8000, 3840);
            end
            1, 5: begin
                r[0] = pack16(16384 - $urandom_range(0, 2000), $urandom_range(0, 4000) - 2000,
                              $urandom_range(0, 4000) - 2000);
                r[1] = pack16($urandom_range(0, 4000) - 2000, 16384 - $urandom_range(0, 2000),
                              $urandom_range(0, 4000) - 2000);
                r[2] = pack16($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                              16384 - $urandom_range(0, 2000));
                r[3] = pack16($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                              $urandom_range(0, 2000) - 1000);
                r[4] = pack20($urandom_range(4000, 20000), $urandom_range(0, 40) - 20,
                              $urandom_range(0, 10240));
                r[5] = pack20($urandom_range(0, 40) - 20, $urandom_range(4000, 20000),
                              $urandom_range(0, 7680));
            end
            2: for (int i = 0; i < 6; i++) r[i] = '1;
            3: begin
                for (int i = 0; i < 4; i++) r[i] = pack16(-32768, -32768, -32768);
                r[4] = pack20(-524288, -524288, -524288);
                r[5] = pack20(-524288, -524288, -524288);
            end
            default: for (int i = 0; i < 6; i++) r[i] = CFG_DATA_W'({$urandom, $urandom});
        endcase
        write_reg(IDX_ROT_X, r[0]);
        write_reg(IDX_ROT_Y, r[1]);
        write_reg(IDX_ROT_Z, r[2]);
        write_reg(IDX_TRANS, r[3]);
        write_reg(IDX_INTR_U, r[4]);
        write_reg(IDX_INTR_V, r[5]);
        if (phase == 1)
            write_reg(IDX_SPARE, '1);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        rst_n      = 1'b0;
        push       = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        point_x_mm = '0;
        point_y_mm = '0;
        point_z_mm = '0;
        hold_req   = 1'b0;
        no_idle    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All registers still zero: every point has zero depth.
        send_point(1000, -1000, 5000);

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            configure(phase);
            if (phase == 0) begin
                // Extremes, zero and negative depth, rounding and clipping.
                send_point(524287, 524287, 524287);
                send_point(-524288, -524288, 524287);
                send_point(524287, -524288, 1);
                send_point(-524288, 524287, 1);
                send_point(0, 0, 0);
                send_point(100, 100, 0);
                send_point(0, 0, -1);
                send_point(-524288, -524288, -524288);
                send_point(0, 0, 1);
                send_point(1, 1, 2);
                send_point(-1, -1, 2);
                send_point(3, -3, 2);
                send_point(0, 0, 524287);
                send_point(20000, -15000, 100000);
            end
            if (phase == 2)
                hold_req = 1'b1;
            if (phase == 5)
                no_idle = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_point();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lppu_pkg.sv
rtl/lppu_cfg.sv
rtl/lppu_front.sv
rtl/lppu_back.sv
rtl/lidar_point_to_pixel_projection_unit.sv
rtl/lppu_checker.sv
test/lidar_point_to_pixel_projection_unit_checker.sv
test/lidar_point_to_pixel_projection_unit_tb.sv
